// ===== rtl/arpc_pkg.sv =====
`default_nettype none
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF  = 16;
  localparam int unsigned WAITER_ENTRIES_DEF = 8;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 4;
  localparam int unsigned IN_DW   = 120;
  localparam int unsigned OUT_DW  = 64;

  // Seed of the oldest-entry chain; it never wins because the seed is marked empty.
  localparam logic [TICK_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LEARN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd4;

  localparam logic [STAT_W-1:0] ST_HIT       = 4'd0;
  localparam logic [STAT_W-1:0] ST_MISS      = 4'd1;
  localparam logic [STAT_W-1:0] ST_UPDATED   = 4'd2;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 4'd3;
  localparam logic [STAT_W-1:0] ST_WOKEN     = 4'd4;
  localparam logic [STAT_W-1:0] ST_ADDED     = 4'd5;
  localparam logic [STAT_W-1:0] ST_FULL      = 4'd6;
  localparam logic [STAT_W-1:0] ST_CANCELLED = 4'd7;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 4'd8;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 4'd9;

  typedef struct packed {
    logic clear_all;
    logic insert;
    logic update;
  } ent_cmd_t;

  typedef struct packed {
    logic add;
    logic free;
  } wt_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_WAKE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/arpc_entry_cell.sv =====
`default_nettype none
module arpc_entry_cell #(
  parameter int unsigned IW = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  arpc_pkg::ent_cmd_t           cmd,
  input  wire                          sel,
  input  wire [IW-1:0]                 my_idx,
  input  wire [arpc_pkg::IP_W-1:0]     key_ip,
  input  wire [arpc_pkg::MAC_W-1:0]    new_mac,
  input  wire [arpc_pkg::TICK_W-1:0]   new_stamp,
  output logic                         valid,
  output logic                         match,
  output logic [arpc_pkg::MAC_W-1:0]   mac,
  input  wire                          ch_have_in,
  input  wire [arpc_pkg::TICK_W-1:0]   ch_stamp_in,
  input  wire [IW-1:0]                 ch_idx_in,
  output logic                         ch_have_out,
  output logic [arpc_pkg::TICK_W-1:0]  ch_stamp_out,
  output logic [IW-1:0]                ch_idx_out
);

  logic                         valid_r;
  logic [arpc_pkg::IP_W-1:0]    ip_r;
  logic [arpc_pkg::MAC_W-1:0]   mac_r;
  logic [arpc_pkg::TICK_W-1:0]  stamp_r;
  logic                         take_own;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clear_all) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.insert) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.insert) begin
      ip_r    <= key_ip;
      mac_r   <= new_mac;
      stamp_r <= new_stamp;
    end else if (sel && cmd.update) begin
      mac_r <= new_mac;
    end
  end

  // Strict compare keeps the earlier cell on equal stamps.
  assign take_own = !ch_have_in || (stamp_r < ch_stamp_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_have_out <= 1'b0;
    end else begin
      ch_have_out <= 1'b1;
    end
    ch_stamp_out <= take_own ? stamp_r : ch_stamp_in;
    ch_idx_out   <= take_own ? my_idx : ch_idx_in;
  end

  assign valid = valid_r;
  assign match = valid_r && (ip_r == key_ip);
  assign mac   = mac_r;

endmodule
`default_nettype wire

// ===== rtl/arpc_waiter_cell.sv =====
`default_nettype none
module arpc_waiter_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  arpc_pkg::wt_cmd_t           cmd,
  input  wire                         sel,
  input  wire [arpc_pkg::IP_W-1:0]    key_ip,
  input  wire [arpc_pkg::TAG_W-1:0]   new_tag,
  output logic                        valid,
  output logic                        match,
  output logic [arpc_pkg::TAG_W-1:0]  tag
);

  logic                        valid_r;
  logic [arpc_pkg::IP_W-1:0]   ip_r;
  logic [arpc_pkg::TAG_W-1:0]  tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.add) begin
      valid_r <= 1'b1;
    end else if (sel && cmd.free) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.add) begin
      ip_r  <= key_ip;
      tag_r <= new_tag;
    end
  end

  assign valid = valid_r;
  assign match = valid_r && (ip_r == key_ip);
  assign tag   = tag_r;

endmodule
`default_nettype wire

// ===== rtl/arp_cache_with_waiters.sv =====
// IPv4-to-MAC address cache with a table of pending resolution waiters.
// Input channel (in_*): one item is one operation; in_tuser carries the kind
// (lookup, learn, clear cache, add waiter, cancel waiter) and in_tdata the
// address, MAC, tick and waiter tag. Result channel (out_*): out_tuser holds
// the status, out_tdata the MAC, woken tag, waiter-space and evicted flags,
// and out_tlast marks the final result of an item.
// Items are handled one at a time. A lookup, clear, add, cancel or a learn
// that needs no eviction gets its result registered in the execute state; the
// block is ready again in the cycle after that result is taken. A learn
// into a full cache first waits in the scan state for the oldest-entry
// search, which walks a registered chain of one stage per cache cell.
// Each woken waiter adds one result. Unknown kinds produce no result.
// While the receiver stalls, the result register holds and no new item is
// taken. Reset clears all entry and waiter valid bits at once; no clearing
// pass is needed.
`default_nettype none
module arp_cache_with_waiters #(
  parameter int unsigned CACHE_ENTRIES  = arpc_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned WAITER_ENTRIES = arpc_pkg::WAITER_ENTRIES_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // tdata, from bit 0: ip_addr[31:0], mac_addr[79:32], now_tick[111:80], waiter_id[119:112]
  input  wire [arpc_pkg::IN_DW-1:0]        in_tdata,
  // tuser: kind[2:0]
  input  wire [arpc_pkg::KIND_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // tdata, from bit 0: mac_out[47:0], woken_id[55:48], waiter_space[56], evicted[57], zeros
  output logic [arpc_pkg::OUT_DW-1:0]      out_tdata,
  // tuser: status[3:0]
  output logic [arpc_pkg::STAT_W-1:0]      out_tuser,
  output logic                             out_tlast
);

  localparam int unsigned N  = CACHE_ENTRIES;
  localparam int unsigned W  = WAITER_ENTRIES;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);

  // Latched item.
  logic [arpc_pkg::KIND_W-1:0]  kind_r;
  logic [arpc_pkg::IP_W-1:0]    ip_r;
  logic [arpc_pkg::MAC_W-1:0]   mac_r;
  logic [arpc_pkg::TICK_W-1:0]  now_r;
  logic [arpc_pkg::TAG_W-1:0]   id_r;

  arpc_pkg::state_t state_r, state_nxt;
  logic [W-1:0]   wake_r, wake_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  // Result register.
  logic                          ovalid_r, ovalid_nxt;
  logic [arpc_pkg::STAT_W-1:0]   ostat_r, ostat_nxt;
  logic [arpc_pkg::MAC_W-1:0]    omac_r, omac_nxt;
  logic [arpc_pkg::TAG_W-1:0]    owoken_r, owoken_nxt;
  logic                          ospace_r, ospace_nxt;
  logic                          oevict_r, oevict_nxt;
  logic                          olast_r, olast_nxt;

  // Cache cells.
  logic [N-1:0]                  ent_valid, ent_match, ent_sel;
  logic [arpc_pkg::MAC_W-1:0]    ent_mac [N];
  arpc_pkg::ent_cmd_t            ent_cmd;
  logic [N:0]                    ch_have;
  logic [arpc_pkg::TICK_W-1:0]   ch_stamp [N+1];
  logic [IW-1:0]                 ch_idx [N+1];

  // Waiter cells.
  logic [W-1:0]                  wt_valid, wt_match, wt_sel;
  logic [arpc_pkg::TAG_W-1:0]    wt_tag [W];
  arpc_pkg::wt_cmd_t             wt_cmd;

  logic [N-1:0]                  hit_oh, free_oh, evict_oh;
  logic [W-1:0]                  wfree_oh, wmatch_oh, wake_oh, wake_rest;
  logic [arpc_pkg::MAC_W-1:0]    hit_mac;
  logic [arpc_pkg::TAG_W-1:0]    wake_tag;

  assign ch_have[0]  = 1'b0;
  assign ch_stamp[0] = arpc_pkg::STAMP_MAX;
  assign ch_idx[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_ent
    arpc_entry_cell #(.IW(IW)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (ent_cmd),
      .sel          (ent_sel[i]),
      .my_idx       (IW'(i)),
      .key_ip       (ip_r),
      .new_mac      (mac_r),
      .new_stamp    (now_r),
      .valid        (ent_valid[i]),
      .match        (ent_match[i]),
      .mac          (ent_mac[i]),
      .ch_have_in   (ch_have[i]),
      .ch_stamp_in  (ch_stamp[i]),
      .ch_idx_in    (ch_idx[i]),
      .ch_have_out  (ch_have[i+1]),
      .ch_stamp_out (ch_stamp[i+1]),
      .ch_idx_out   (ch_idx[i+1])
    );
    assign evict_oh[i] = (ch_idx[N] == IW'(i));
  end

  for (genvar j = 0; j < W; j++) begin : g_wt
    arpc_waiter_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (wt_cmd),
      .sel     (wt_sel[j]),
      .key_ip  (ip_r),
      .new_tag (id_r),
      .valid   (wt_valid[j]),
      .match   (wt_match[j]),
      .tag     (wt_tag[j])
    );
  end

  // Lowest set bit picks the first slot in index order.
  assign hit_oh    = ent_match & (~ent_match + N'(1));
  assign free_oh   = ~ent_valid & (ent_valid + N'(1));
  assign wfree_oh  = ~wt_valid & (wt_valid + W'(1));
  assign wmatch_oh = wt_match & (~wt_match + W'(1));
  assign wake_oh   = wake_r & (~wake_r + W'(1));
  assign wake_rest = wake_r & ~wake_oh;

  always_comb begin
    hit_mac = '0;
    for (int i = 0; i < N; i++) begin
      hit_mac = hit_mac | (ent_mac[i] & {arpc_pkg::MAC_W{hit_oh[i]}});
    end
  end

  always_comb begin
    wake_tag = '0;
    for (int j = 0; j < W; j++) begin
      wake_tag = wake_tag | (wt_tag[j] & {arpc_pkg::TAG_W{wake_oh[j]}});
    end
  end

  assign in_tready = (state_r == arpc_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    wake_nxt   = wake_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    ostat_nxt  = ostat_r;
    omac_nxt   = omac_r;
    owoken_nxt = owoken_r;
    ospace_nxt = ospace_r;
    oevict_nxt = oevict_r;
    olast_nxt  = olast_r;
    ent_cmd    = '0;
    ent_sel    = '0;
    wt_cmd     = '0;
    wt_sel     = '0;
    unique case (state_r)
      arpc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = arpc_pkg::S_EXEC;
        end
      end
      arpc_pkg::S_EXEC: begin
        // Most operations finish here with a single result.
        ovalid_nxt = 1'b1;
        omac_nxt   = '0;
        owoken_nxt = '0;
        ospace_nxt = 1'b0;
        oevict_nxt = 1'b0;
        olast_nxt  = 1'b1;
        wake_nxt   = '0;
        state_nxt  = arpc_pkg::S_OUT;
        unique case (kind_r)
          arpc_pkg::KIND_LOOKUP: begin
            if (|ent_match) begin
              ostat_nxt = arpc_pkg::ST_HIT;
              omac_nxt  = hit_mac;
            end else begin
              ostat_nxt  = arpc_pkg::ST_MISS;
              ospace_nxt = ~&wt_valid;
            end
          end
          arpc_pkg::KIND_LEARN: begin
            // Waiters are untouched until the wake phase, so capture them now.
            wake_nxt  = wt_match;
            olast_nxt = ~|wt_match;
            if (|ent_match) begin
              ent_cmd.update = 1'b1;
              ent_sel        = hit_oh;
              ostat_nxt      = arpc_pkg::ST_UPDATED;
            end else if (~&ent_valid) begin
              ent_cmd.insert = 1'b1;
              ent_sel        = free_oh;
              ostat_nxt      = arpc_pkg::ST_INSERTED;
            end else begin
              // Cache full: let the oldest-entry chain settle first.
              ovalid_nxt = 1'b0;
              cnt_nxt    = '0;
              state_nxt  = arpc_pkg::S_SCAN;
            end
          end
          arpc_pkg::KIND_CLEAR: begin
            ent_cmd.clear_all = 1'b1;
            ostat_nxt         = arpc_pkg::ST_CLEARED;
          end
          arpc_pkg::KIND_ADD: begin
            if (~&wt_valid) begin
              wt_cmd.add = 1'b1;
              wt_sel     = wfree_oh;
              ostat_nxt  = arpc_pkg::ST_ADDED;
            end else begin
              ostat_nxt = arpc_pkg::ST_FULL;
            end
          end
          arpc_pkg::KIND_CANCEL: begin
            if (|wt_match) begin
              wt_cmd.free = 1'b1;
              wt_sel      = wmatch_oh;
              ostat_nxt   = arpc_pkg::ST_CANCELLED;
            end else begin
              ostat_nxt = arpc_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            // Unknown kind: no result at all.
            ovalid_nxt = 1'b0;
            state_nxt  = arpc_pkg::S_IDLE;
          end
        endcase
      end
      arpc_pkg::S_SCAN: begin
        if (cnt_r == CW'(N)) begin
          ent_cmd.insert = 1'b1;
          ent_sel        = evict_oh;
          ovalid_nxt     = 1'b1;
          ostat_nxt      = arpc_pkg::ST_INSERTED;
          oevict_nxt     = 1'b1;
          state_nxt      = arpc_pkg::S_OUT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      arpc_pkg::S_WAKE: begin
        wt_cmd.free = 1'b1;
        wt_sel      = wake_oh;
        wake_nxt    = wake_rest;
        ovalid_nxt  = 1'b1;
        ostat_nxt   = arpc_pkg::ST_WOKEN;
        omac_nxt    = '0;
        owoken_nxt  = wake_tag;
        ospace_nxt  = 1'b0;
        oevict_nxt  = 1'b0;
        olast_nxt   = ~|wake_rest;
        state_nxt   = arpc_pkg::S_OUT;
      end
      arpc_pkg::S_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = (|wake_r) ? arpc_pkg::S_WAKE : arpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = arpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= arpc_pkg::S_IDLE;
      ovalid_r <= 1'b0;
      wake_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      wake_r   <= wake_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      ip_r   <= in_tdata[31:0];
      mac_r  <= in_tdata[79:32];
      now_r  <= in_tdata[111:80];
      id_r   <= in_tdata[119:112];
    end
    ostat_r  <= ostat_nxt;
    omac_r   <= omac_nxt;
    owoken_r <= owoken_nxt;
    ospace_r <= ospace_nxt;
    oevict_r <= oevict_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, oevict_r, ospace_r, owoken_r, omac_r};

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int NCACHE  = 16;
  localparam int NWAIT   = 8;
  localparam int LIMIT   = 400000;

  // One expected result of the cache.
  typedef struct packed {
    logic [arpc_pkg::STAT_W-1:0] status;
    logic [arpc_pkg::MAC_W-1:0]  mac;
    logic [arpc_pkg::TAG_W-1:0]  woken;
    logic                        space;
    logic                        evicted;
    logic                        last;
  } arp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [arpc_pkg::IN_DW-1:0] in_tdata = '0;
  logic [arpc_pkg::KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [arpc_pkg::OUT_DW-1:0] out_tdata;
  logic [arpc_pkg::STAT_W-1:0] out_tuser;
  logic out_tlast;

  always #2 clk = ~clk;

  arp_cache_with_waiters dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Shadow copy of the cache and waiter tables.
  logic                        shadow_ent_v[NCACHE];
  logic [arpc_pkg::IP_W-1:0]   shadow_ent_ip[NCACHE];
  logic [arpc_pkg::MAC_W-1:0]  shadow_ent_mac[NCACHE];
  logic [arpc_pkg::TICK_W-1:0] shadow_ent_stamp[NCACHE];
  logic                        shadow_wt_v[NWAIT];
  logic [arpc_pkg::IP_W-1:0]   shadow_wt_ip[NWAIT];
  logic [arpc_pkg::TAG_W-1:0]  shadow_wt_tag[NWAIT];

  arp_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  // Pool of addresses so that hits, wakes and cancels are common.
  logic [arpc_pkg::IP_W-1:0] ip_pool[8];

  function automatic arp_result_t mk_result(logic [arpc_pkg::STAT_W-1:0] st,
                                            logic [arpc_pkg::MAC_W-1:0] m,
                                            logic [arpc_pkg::TAG_W-1:0] w, logic sp,
                                            logic ev);
    arp_result_t r;
    r.status = st; r.mac = m; r.woken = w; r.space = sp; r.evicted = ev; r.last = 1'b1;
    return r;
  endfunction

  // Apply one operation to the shadow tables and queue the results it causes.
  task automatic predict_op(logic [arpc_pkg::KIND_W-1:0] kind, logic [arpc_pkg::IP_W-1:0] ip,
                            logic [arpc_pkg::MAC_W-1:0] mac,
                            logic [arpc_pkg::TICK_W-1:0] tick,
                            logic [arpc_pkg::TAG_W-1:0] tag);
    int hit;
    int slot;
    logic ev;
    logic [arpc_pkg::STAT_W-1:0] st;
    arp_result_t r;
    hit = -1;
    slot = -1;
    ev = 1'b0;
    for (int i = NCACHE - 1; i >= 0; i--)
      if (shadow_ent_v[i] && shadow_ent_ip[i] == ip) hit = i;
    case (kind)
      arpc_pkg::KIND_LOOKUP: begin
        if (hit >= 0) begin
          pending_results.push_back(mk_result(arpc_pkg::ST_HIT, shadow_ent_mac[hit], '0,
                                              1'b0, 1'b0));
        end else begin
          for (int i = 0; i < NWAIT; i++) if (!shadow_wt_v[i]) slot = i;
          pending_results.push_back(mk_result(arpc_pkg::ST_MISS, '0, '0, slot >= 0, 1'b0));
        end
      end
      arpc_pkg::KIND_LEARN: begin
        if (hit >= 0) begin
          shadow_ent_mac[hit] = mac;
          st = arpc_pkg::ST_UPDATED;
        end else begin
          for (int i = NCACHE - 1; i >= 0; i--) if (!shadow_ent_v[i]) slot = i;
          if (slot < 0) begin
            // Cache full: the smallest stamp goes, lowest index on ties.
            slot = 0;
            for (int i = 1; i < NCACHE; i++)
              if (shadow_ent_stamp[i] < shadow_ent_stamp[slot]) slot = i;
            ev = 1'b1;
          end
          shadow_ent_v[slot] = 1'b1;
          shadow_ent_ip[slot] = ip;
          shadow_ent_mac[slot] = mac;
          shadow_ent_stamp[slot] = tick;
          st = arpc_pkg::ST_INSERTED;
        end
        pending_results.push_back(mk_result(st, '0, '0, 1'b0, ev));
        for (int i = 0; i < NWAIT; i++) begin
          if (shadow_wt_v[i] && shadow_wt_ip[i] == ip) begin
            r = pending_results.pop_back();
            r.last = 1'b0;
            pending_results.push_back(r);
            pending_results.push_back(mk_result(arpc_pkg::ST_WOKEN, '0, shadow_wt_tag[i],
                                                1'b0, 1'b0));
            shadow_wt_v[i] = 1'b0;
          end
        end
      end
      arpc_pkg::KIND_CLEAR: begin
        for (int i = 0; i < NCACHE; i++) shadow_ent_v[i] = 1'b0;
        pending_results.push_back(mk_result(arpc_pkg::ST_CLEARED, '0, '0, 1'b0, 1'b0));
      end
      arpc_pkg::KIND_ADD: begin
        for (int i = NWAIT - 1; i >= 0; i--) if (!shadow_wt_v[i]) slot = i;
        if (slot >= 0) begin
          shadow_wt_v[slot] = 1'b1;
          shadow_wt_ip[slot] = ip;
          shadow_wt_tag[slot] = tag;
          pending_results.push_back(mk_result(arpc_pkg::ST_ADDED, '0, '0, 1'b0, 1'b0));
        end else begin
          pending_results.push_back(mk_result(arpc_pkg::ST_FULL, '0, '0, 1'b0, 1'b0));
        end
      end
      arpc_pkg::KIND_CANCEL: begin
        for (int i = NWAIT - 1; i >= 0; i--)
          if (shadow_wt_v[i] && shadow_wt_ip[i] == ip) slot = i;
        if (slot >= 0) shadow_wt_v[slot] = 1'b0;
        pending_results.push_back(mk_result(slot >= 0 ? arpc_pkg::ST_CANCELLED
                                                      : arpc_pkg::ST_NOTFOUND,
                                             '0, '0, 1'b0, 1'b0));
      end
      default: ;  // Unknown kinds are ignored by the block.
    endcase
  endtask

  // Send one item. The sender works in bursts: between bursts it may drop valid
  // for a random gap; within a burst, valid stays high from item to item.
  task automatic send_op(logic [arpc_pkg::KIND_W-1:0] kind, logic [arpc_pkg::IP_W-1:0] ip,
                         logic [arpc_pkg::MAC_W-1:0] mac, logic [arpc_pkg::TICK_W-1:0] tick,
                         logic [arpc_pkg::TAG_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {tag, tick, mac, ip};
    predict_op(kind, ip, mac, tick, tag);
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, end the burst and wait on the clock so the next item starts on a later edge.
  task automatic go_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Receiver stall pattern: a free-running phase with stall-heavy stretches,
  // fully ready stretches and random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case ((cycles / 97) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    arp_result_t exp_r;
    arp_result_t got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = mk_result(out_tuser, out_tdata[47:0], out_tdata[55:48], out_tdata[56],
                      out_tdata[57]);
      got.last = out_tlast;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d tdata=%h last=%b",
                   out_tuser, out_tdata, out_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r || out_tdata[63:58] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch: exp st=%0d mac=%h woken=%h sp=%b ev=%b last=%b",
                     exp_r.status, exp_r.mac, exp_r.woken, exp_r.space, exp_r.evicted,
                     exp_r.last,
                     "\n       got st=%0d mac=%h woken=%h sp=%b ev=%b last=%b tdata=%h",
                     got.status, got.mac, got.woken, got.space, got.evicted, got.last,
                     out_tdata);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [arpc_pkg::IP_W-1:0] pick_ip();
    return ($urandom_range(0, 4) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[arpc_pkg::MAC_W-1:0];
  endfunction

  function automatic logic [arpc_pkg::TAG_W-1:0] rand_tag();
    logic [31:0] v;
    v = $urandom();
    return v[arpc_pkg::TAG_W-1:0];
  endfunction

  // Extremes of every field and every operation, including unknown kinds.
  task automatic test_directed();
    send_op(arpc_pkg::KIND_LOOKUP, 32'h0, '0, '0, '0);
    send_op(arpc_pkg::KIND_CANCEL, 32'hFFFF_FFFF, '0, '0, '0);
    send_op(arpc_pkg::KIND_ADD, 32'hFFFF_FFFF, '0, '0, 8'hFF);
    send_op(arpc_pkg::KIND_ADD, 32'hFFFF_FFFF, '0, '0, 8'h00);
    send_op(arpc_pkg::KIND_ADD, 32'h0, '0, '0, 8'h5A);
    send_op(arpc_pkg::KIND_LEARN, 32'hFFFF_FFFF, {arpc_pkg::MAC_W{1'b1}}, 32'hFFFF_FFFF,
            8'hFF);
    send_op(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
    send_op(arpc_pkg::KIND_LEARN, 32'hFFFF_FFFF, 48'h0, 32'h0, '0);
    send_op(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
    send_op(arpc_pkg::KIND_CANCEL, 32'h0, '0, '0, '0);
    send_op(arpc_pkg::KIND_CANCEL, 32'h0, '0, '0, '0);
    send_op(3'd5, 32'h0, '0, '0, '0);
    send_op(3'd6, 32'hFFFF_FFFF, {arpc_pkg::MAC_W{1'b1}}, '1, '1);
    send_op(3'd7, 32'h1, '0, '0, '0);
    send_op(arpc_pkg::KIND_CLEAR, '0, '0, '0, '0);
    send_op(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
    go_idle();
  endtask

  // Fill the waiter table past full, then wake a whole table with one learn.
  task automatic test_waiter_table();
    for (int i = 0; i < NWAIT + 1; i++)
      send_op(arpc_pkg::KIND_ADD, ip_pool[0], '0, '0, 8'(i * 29 + 3));
    send_op(arpc_pkg::KIND_LOOKUP, 32'hDEAD_BEEF, '0, '0, '0);
    send_op(arpc_pkg::KIND_LEARN, ip_pool[0], rand_mac(), $urandom(), '0);
    go_idle();
  endtask

  // Fill the cache and keep learning new addresses so evictions happen,
  // including stamp ties.
  task automatic test_eviction();
    for (int i = 0; i < NCACHE + 6; i++)
      send_op(arpc_pkg::KIND_LEARN, 32'h0A00_0000 + i, rand_mac(),
              (i % 3 == 0) ? 32'd7 : $urandom_range(0, 20), '0);
    for (int i = 0; i < 4; i++)
      send_op(arpc_pkg::KIND_LOOKUP, 32'h0A00_0000 + $urandom_range(0, NCACHE + 5), '0, '0,
              '0);
    go_idle();
  endtask

  // Random mix drawn mostly from a small address pool.
  task automatic test_random_mix();
    int k;
    for (int n = 0; n < 50; n++) begin
      k = $urandom_range(0, 99);
      if (k < 25)
        send_op(arpc_pkg::KIND_LOOKUP, pick_ip(), rand_mac(), $urandom(), rand_tag());
      else if (k < 50)
        send_op(arpc_pkg::KIND_LEARN, pick_ip(), rand_mac(), $urandom(), rand_tag());
      else if (k < 54)
        send_op(arpc_pkg::KIND_CLEAR, $urandom(), rand_mac(), $urandom(), rand_tag());
      else if (k < 78)
        send_op(arpc_pkg::KIND_ADD, pick_ip(), rand_mac(), $urandom(), rand_tag());
      else if (k < 96)
        send_op(arpc_pkg::KIND_CANCEL, pick_ip(), rand_mac(), $urandom(), rand_tag());
      else
        send_op(3'($urandom_range(5, 7)), $urandom(), rand_mac(), $urandom(), rand_tag());
    end
    go_idle();
  endtask

  initial begin
    for (int i = 0; i < NCACHE; i++) shadow_ent_v[i] = 1'b0;
    for (int i = 0; i < NWAIT; i++) shadow_wt_v[i] = 1'b0;
    for (int i = 0; i < 8; i++) ip_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_waiter_table();
    test_eviction();
    test_random_mix();

    // Drain what is still expected, then keep the clock running so stray results are caught.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/arpc_pkg.sv
rtl/arpc_entry_cell.sv
rtl/arpc_waiter_cell.sv
rtl/arp_cache_with_waiters.sv
sim/tb_top.sv
